[src/hfd_pkg.sv]
package hfd_pkg;

   localparam int HFD_NODE_COUNT = 256;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_DECODE = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0] right_child;
      logic       right_present;
      logic [7:0] left_child;
      logic       left_present;
      logic [7:0] symbol;
   } node_type;

   typedef struct packed {
      op_type     op;
      logic       code_bit;
      logic [7:0] node_index;
      node_type   node;
   } item_type;

   typedef struct packed {
      logic       we;
      logic [7:0] idx;
      node_type   node;
   } wr_port_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] symbol;
      logic       flushed;
      logic       bit_dropped;
   } result_type;

endpackage

[src/hfd_node_mem.sv]
module hfd_node_mem import hfd_pkg::*; #(
   parameter int NODE_COUNT = HFD_NODE_COUNT
) (
   input  logic        clock,
   input  wr_port_type wr,
   input  logic [7:0]  cur_idx,
   input  logic [7:0]  root_idx,
   output node_type    cur_node,
   output node_type    root_node
);

   localparam int AW = $clog2(NODE_COUNT);

   node_type mem [NODE_COUNT];

   node_type cur_q_ff;
   node_type root_q_ff;
   node_type wdata_ff;
   logic     cur_ok_ff;
   logic     root_ok_ff;
   logic     cur_fwd_ff;
   logic     root_fwd_ff;

   logic wr_ok;
   logic cur_ok_in;
   logic root_ok_in;

   assign wr_ok      = wr.we && ({24'd0, wr.idx} < 32'(NODE_COUNT));
   assign cur_ok_in  = {24'd0, cur_idx} < 32'(NODE_COUNT);
   assign root_ok_in = {24'd0, root_idx} < 32'(NODE_COUNT);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[AW'(wr.idx)] <= wr.node;
      end
      cur_q_ff    <= mem[AW'(cur_idx)];
      root_q_ff   <= mem[AW'(root_idx)];
      wdata_ff    <= wr.node;
      cur_ok_ff   <= cur_ok_in;
      root_ok_ff  <= root_ok_in;
      cur_fwd_ff  <= wr_ok && (wr.idx == cur_idx);
      root_fwd_ff <= wr_ok && (wr.idx == root_idx);
   end

   always_comb begin
      if (!cur_ok_ff) begin
         cur_node = '0;
      end else if (cur_fwd_ff) begin
         cur_node = wdata_ff;
      end else begin
         cur_node = cur_q_ff;
      end
      if (!root_ok_ff) begin
         root_node = '0;
      end else if (root_fwd_ff) begin
         root_node = wdata_ff;
      end else begin
         root_node = root_q_ff;
      end
   end

   a_cur_fwd: assert property (@(posedge clock)
      (wr_ok && wr.idx == cur_idx) |=> cur_node == $past(wr.node))
      else $error("cursor read missed same-cycle write");

   a_root_fwd: assert property (@(posedge clock)
      (wr_ok && wr.idx == root_idx) |=> root_node == $past(wr.node))
      else $error("root read missed same-cycle write");

   a_out_of_range: assert property (@(posedge clock)
      !cur_ok_in |=> cur_node == '0)
      else $error("out-of-range node not zero");

endmodule

[src/hfd_walk.sv]
module hfd_walk import hfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   input  item_type    req_item,
   output logic        req_ready,
   output wr_port_type wr,
   output logic [7:0]  rd_cur_idx,
   output logic [7:0]  rd_root_idx,
   input  node_type    cur_node,
   input  node_type    root_node,
   output result_type  res,
   input  logic        res_free
);

   logic       ex_valid_ff;
   item_type   ex_item_ff;
   logic [7:0] cursor_ff;
   logic [7:0] cursor_in;
   logic [7:0] root_ff;
   logic [7:0] root_in;

   logic       cur_has;
   logic [7:0] cur_child;
   logic       root_has;
   logic [7:0] root_child;
   logic       need_out;
   logic       advance;

   always_comb begin
      cur_has    = ex_item_ff.code_bit ? cur_node.right_present : cur_node.left_present;
      cur_child  = ex_item_ff.code_bit ? cur_node.right_child : cur_node.left_child;
      root_has   = ex_item_ff.code_bit ? root_node.right_present : root_node.left_present;
      root_child = ex_item_ff.code_bit ? root_node.right_child : root_node.left_child;

      need_out  = (ex_item_ff.op == OP_DECODE && !cur_has) || (ex_item_ff.op == OP_FLUSH);
      advance   = ex_valid_ff && (!need_out || res_free);
      req_ready = !ex_valid_ff || advance;

      cursor_in = cursor_ff;
      root_in   = root_ff;
      if (csr_wr_en) begin
         root_in   = csr_wr_data;
         cursor_in = csr_wr_data;
      end else if (advance) begin
         unique case (ex_item_ff.op)
            OP_DECODE: begin
               if (cur_has) begin
                  cursor_in = cur_child;
               end else if (root_has) begin
                  cursor_in = root_child;
               end else begin
                  cursor_in = root_ff;
               end
            end
            OP_FLUSH: begin
               cursor_in = root_ff;
            end
            OP_WRITE: begin
               cursor_in = cursor_ff;
            end
            OP_NONE: begin
               cursor_in = cursor_ff;
            end
         endcase
      end

      res.valid       = advance && need_out;
      res.symbol      = cur_node.symbol;
      res.flushed     = ex_item_ff.op == OP_FLUSH;
      res.bit_dropped = ex_item_ff.op == OP_DECODE && !root_has;

      wr.we   = advance && ex_item_ff.op == OP_WRITE;
      wr.idx  = ex_item_ff.node_index;
      wr.node = ex_item_ff.node;

      rd_cur_idx  = cursor_in;
      rd_root_idx = root_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         cursor_ff   <= 8'd0;
         root_ff     <= 8'd0;
      end else begin
         cursor_ff <= cursor_in;
         root_ff   <= root_in;
         if (req_ready) begin
            ex_valid_ff <= req_valid;
         end
      end
      if (req_ready) begin
         ex_item_ff <= req_item;
      end
   end

   a_csr_root: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (root_ff == $past(csr_wr_data)) && (cursor_ff == root_ff))
      else $error("root write did not restart walk");

   a_flush_root: assert property (@(posedge clock) disable iff (reset)
      (advance && ex_item_ff.op == OP_FLUSH && !csr_wr_en) |=> cursor_ff == root_ff)
      else $error("flush did not return to root");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !(res.flushed && res.bit_dropped))
      else $error("flush result flagged as dropped");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && !advance && !csr_wr_en) |=> $stable(cursor_ff) && ex_valid_ff)
      else $error("stalled item moved the cursor");

endmodule

[src/huffman_tree_bit_decoder_unit.sv]
// channel  dir  handshake            tdata                         tuser
// req      in   req_tvalid/tready    code bit, index, node fields  op
// rsp      out  rsp_tvalid/tready    symbol                        flushed, bit_dropped
// csr      in   csr_wr_en            root_index                    -
//
// One item per cycle when the result side keeps up; each item is registered
// together with the node table read at the cursor that the previous item leaves
// (forwarded on the read address), and its result goes to the output register.
// Reset clears the cursor, root and valid flags; the node table is not cleared.
// A decode or flush that yields a symbol waits while the output register is full and not being taken.
module huffman_tree_bit_decoder_unit import hfd_pkg::*; #(
   parameter int NODE_COUNT = HFD_NODE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // code_bit, node_index, node_symbol, left_present, left_child,
   // right_present, right_child, zero fill
   input  logic [39:0] req_tdata,
   // op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // symbol
   output logic [7:0]  rsp_tdata,
   // flushed, bit_dropped
   output logic [1:0]  rsp_tuser
);

   item_type    req_item;
   wr_port_type wr;
   logic [7:0]  rd_cur_idx;
   logic [7:0]  rd_root_idx;
   node_type    cur_node;
   node_type    root_node;
   result_type  res;
   logic        res_free;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_symbol_ff;
   logic [1:0]  rsp_flags_ff;

   always_comb begin
      req_item.op                 = op_type'(req_tuser);
      req_item.code_bit           = req_tdata[0];
      req_item.node_index         = req_tdata[8:1];
      req_item.node.symbol        = req_tdata[16:9];
      req_item.node.left_present  = req_tdata[17];
      req_item.node.left_child    = req_tdata[25:18];
      req_item.node.right_present = req_tdata[26];
      req_item.node.right_child   = req_tdata[34:27];
   end

   assign res_free = !rsp_valid_ff || rsp_tready;

   hfd_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_tvalid),
      .req_item    (req_item),
      .req_ready   (req_tready),
      .wr          (wr),
      .rd_cur_idx  (rd_cur_idx),
      .rd_root_idx (rd_root_idx),
      .cur_node    (cur_node),
      .root_node   (root_node),
      .res         (res),
      .res_free    (res_free)
   );

   hfd_node_mem #(
      .NODE_COUNT (NODE_COUNT)
   ) u_mem (
      .clock     (clock),
      .wr        (wr),
      .cur_idx   (rd_cur_idx),
      .root_idx  (rd_root_idx),
      .cur_node  (cur_node),
      .root_node (root_node)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid) begin
         rsp_symbol_ff <= res.symbol;
         rsp_flags_ff  <= {res.bit_dropped, res.flushed};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule
